>>> hdl/modexp_pkg.sv
// Shared types and constants for the modular exponentiation unit.
// No dependencies; imported by modexp_mont, modular_exponentiation_unit and its testbench.
`timescale 1ns / 1ps

package modexp_pkg;

  // Operand width of a residue and width of the exponent word.
  localparam int unsigned RES_W = 30;
  localparam int unsigned EXP_W = 32;
  localparam int unsigned PROD_W = 2 * RES_W;

  // Prime modulus and Montgomery constants for R = 2^RES_W.
  localparam logic [RES_W-1:0] MODULUS = 30'd1000000007;
  localparam logic [RES_W-1:0] MONT_ONE = 30'((64'd1 << RES_W) % 64'd1000000007);
  localparam logic [RES_W-1:0] MONT_R2 =
      30'((64'(MONT_ONE) * 64'(MONT_ONE)) % 64'd1000000007);
  localparam logic [RES_W-1:0] RES_ONE = 30'd1;

  // Negated inverse of the modulus mod 2^RES_W, by Newton iteration.
  function automatic logic [RES_W-1:0] mont_nprime();
    logic [RES_W-1:0] x;
    x = MODULUS;
    for (int i = 0; i < 5; i++) begin
      x = x * (30'd2 - MODULUS * x);
    end
    return (~x) + 30'd1;
  endfunction

  localparam logic [RES_W-1:0] MONT_NPRIME = mont_nprime();

  // Phases of one Montgomery product after its first multiply.
  typedef enum logic [1:0] {
    PH_MUL_M,
    PH_MUL_P,
    PH_RED
  } mont_phase_e;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SQR,
    ST_MUL,
    ST_FINAL,
    ST_DONE
  } seq_state_e;

  // Request to and response from the Montgomery multiplier.
  typedef struct packed {
    logic             start;
    logic [RES_W-1:0] a;
    logic [RES_W-1:0] b;
  } mont_req_t;

  typedef struct packed {
    logic             done;
    logic [RES_W-1:0] result;
  } mont_rsp_t;

endpackage

>>> hdl/modexp_mont.sv
// Montgomery multiplier on one shared 30x30 multiplier: a*b, then phases MUL_M, MUL_P, RED.
// Depends on modexp_pkg for constants, phase enum and request/response types.
`timescale 1ns / 1ps

module modexp_mont (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  modexp_pkg::mont_req_t req_i,
  output modexp_pkg::mont_rsp_t rsp_o
);
  import modexp_pkg::*;

  logic              busy_q, busy_d;
  mont_phase_e       phase_q, phase_d;
  logic [PROD_W-1:0] prod_q;
  logic [RES_W-1:0]  m_q;
  logic [PROD_W-1:0] mp_q;

  logic [RES_W-1:0]  op_x, op_y;
  logic [PROD_W-1:0] mul_out;
  logic [PROD_W:0]   red_sum;
  logic [RES_W:0]    red_u;
  logic              take;

  assign take = req_i.start && !busy_q;

  // Select multiplier operands by phase
  always_comb begin
    op_x = req_i.a;
    op_y = req_i.b;
    if (busy_q) begin
      case (phase_q)
        PH_MUL_M: begin
          op_x = prod_q[RES_W-1:0];
          op_y = MONT_NPRIME;
        end
        PH_MUL_P: begin
          op_x = m_q;
          op_y = MODULUS;
        end
        default: begin
          op_x = req_i.a;
          op_y = req_i.b;
        end
      endcase
    end
  end

  assign mul_out = {{RES_W{1'b0}}, op_x} * {{RES_W{1'b0}}, op_y};

  // Add m*P, drop the low half, reduce once
  assign red_sum = {1'b0, prod_q} + {1'b0, mp_q};
  assign red_u   = red_sum[PROD_W:RES_W];

  always_comb begin
    rsp_o.done   = busy_q && (phase_q == PH_RED);
    rsp_o.result = (red_u >= {1'b0, MODULUS}) ? RES_W'(red_u - {1'b0, MODULUS})
                                               : red_u[RES_W-1:0];
  end

  // Advance phase
  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    if (take) begin
      busy_d  = 1'b1;
      phase_d = PH_MUL_M;
    end else if (busy_q) begin
      case (phase_q)
        PH_MUL_M: phase_d = PH_MUL_P;
        PH_MUL_P: phase_d = PH_RED;
        default:  busy_d  = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= PH_MUL_M;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
    end
  end

  // Hold partial products
  always_ff @(posedge clk_i) begin
    if (take) begin
      prod_q <= mul_out;
    end
    if (busy_q && (phase_q == PH_MUL_M)) begin
      m_q <= mul_out[RES_W-1:0];
    end
    if (busy_q && (phase_q == PH_MUL_P)) begin
      mp_q <= mul_out;
    end
  end

endmodule

>>> hdl/modular_exponentiation_unit.sv
// Top level: base^exponent mod 1000000007 by square-and-multiply.
// Depends on modexp_pkg and modexp_mont.
`timescale 1ns / 1ps
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+-----------------------------
//  in      | input     | in_valid_i / in_ready_o   | base_value_i, exponent_i
//  out     | output    | out_valid_o / out_ready_i | power_result_o
//
//  Every Montgomery product runs on the single 30x30 multiplier: one square
//  per exponent bit plus one multiply per set bit, between the conversion
//  of the base and the final product that leaves Montgomery form.
//  in_ready_o is high only while the sequencer is idle; a finished result
//  sits in the output register and a new word may be taken meanwhile.
//  Reset clears the sequencer and the output valid; no other state is kept.

module modular_exponentiation_unit #(
  parameter int unsigned EXP_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [modexp_pkg::RES_W-1:0]  base_value_i,
  input  logic [modexp_pkg::EXP_W-1:0]  exponent_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [modexp_pkg::RES_W-1:0]  power_result_o
);
  import modexp_pkg::*;

  localparam int unsigned BIT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

  seq_state_e          state_q, state_d;
  logic                pend_q, pend_d;
  logic [RES_W-1:0]    acc_q, bm_q, base_q;
  logic [EXP_BITS-1:0] exp_sh_q;
  logic [BIT_W-1:0]    cnt_q;
  logic                out_valid_q, out_valid_d;
  logic [RES_W-1:0]    out_q;

  logic [EXP_BITS-1:0] exp_load;
  logic [RES_W-1:0]    base_red;
  logic                in_take, exp_bit, last_bit, bit_step, out_load;
  mont_req_t           mreq;
  mont_rsp_t           mrsp;

  // Align exponent so its top scanned bit sits at the MSB
  if (EXP_BITS <= EXP_W) begin : g_exp_trunc
    assign exp_load = exponent_i[EXP_BITS-1:0];
  end else begin : g_exp_ext
    assign exp_load = {{(EXP_BITS - EXP_W){1'b0}}, exponent_i};
  end

  // Reduce the base once
  assign base_red = (base_value_i >= MODULUS) ? (base_value_i - MODULUS) : base_value_i;

  assign exp_bit  = exp_sh_q[EXP_BITS-1];
  assign last_bit = (cnt_q == '0);
  assign in_take  = in_valid_i && in_ready_o;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign bit_step = mrsp.done && !last_bit &&
                    (((state_q == ST_SQR) && !exp_bit) || (state_q == ST_MUL));

  modexp_mont u_mont (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_CONV;
      ST_CONV:  if (mrsp.done) state_d = ST_SQR;
      ST_SQR: begin
        if (mrsp.done) begin
          if (exp_bit) begin
            state_d = ST_MUL;
          end else if (last_bit) begin
            state_d = ST_FINAL;
          end
        end
      end
      ST_MUL: begin
        if (mrsp.done) state_d = last_bit ? ST_FINAL : ST_SQR;
      end
      ST_FINAL: if (mrsp.done) state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Handshake and multiplier requests
  always_comb begin
    in_ready_o = 1'b0;
    mreq.start = 1'b0;
    mreq.a     = '0;
    mreq.b     = '0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_CONV: begin
        mreq.start = !pend_q;
        mreq.a     = base_q;
        mreq.b     = MONT_R2;
      end
      ST_SQR: begin
        mreq.start = !pend_q;
        mreq.a     = acc_q;
        mreq.b     = acc_q;
      end
      ST_MUL: begin
        mreq.start = !pend_q;
        mreq.a     = acc_q;
        mreq.b     = bm_q;
      end
      ST_FINAL: begin
        mreq.start = !pend_q;
        mreq.a     = acc_q;
        mreq.b     = RES_ONE;
      end
      default: in_ready_o = 1'b0;
    endcase
  end

  // Track an outstanding product
  always_comb begin
    pend_d = pend_q;
    if (mreq.start) begin
      pend_d = 1'b1;
    end else if (mrsp.done) begin
      pend_d = 1'b0;
    end
  end

  // Hold the output word until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Operands, accumulator and exponent scan
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      base_q   <= base_red;
      acc_q    <= MONT_ONE;
      exp_sh_q <= exp_load;
      cnt_q    <= BIT_W'(EXP_BITS - 1);
    end else begin
      if (mrsp.done) begin
        if (state_q == ST_CONV) begin
          bm_q <= mrsp.result;
        end else begin
          acc_q <= mrsp.result;
        end
      end
      if (bit_step) begin
        exp_sh_q <= exp_sh_q << 1;
        cnt_q    <= cnt_q - 1'b1;
      end
    end
    if (out_load) begin
      out_q <= acc_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign power_result_o = out_q;

  // Checks
  a_done_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mrsp.done |-> pend_q)
    else $error("product finished with none outstanding");

  a_result_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (power_result_o < MODULUS))
    else $error("result not reduced below modulus");

  a_mul_after_sqr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) && ($past(state_q) != ST_MUL) |-> ($past(state_q) == ST_SQR))
    else $error("multiply step not preceded by square");

  a_no_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> (state_q == ST_CONV) && !pend_q)
    else $error("word accepted without starting conversion");

endmodule

>>> verif/modular_exponentiation_unit_test.sv
// Self-checking testbench for modular_exponentiation_unit: random and directed words,
// random idling on both channels, results checked against a built-in predictor.
// Depends on modexp_pkg and the RTL of modular_exponentiation_unit.
`timescale 1ns / 1ps

module modular_exponentiation_unit_test;
  import modexp_pkg::*;

  localparam int unsigned EXP_BITS = 32;
  localparam int unsigned RANDOM_WORDS = 1800;
  localparam int unsigned HOLD_OFF_CYCLES = 2500;
  localparam int unsigned HOLD_OFF_AFTER = 400;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam logic [RES_W-1:0] RES_MAX = '1;
  localparam logic [EXP_W-1:0] EXP_MAX = '1;

  typedef struct packed {
    logic [RES_W-1:0] base;
    logic [EXP_W-1:0] expo;
  } mod_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [RES_W-1:0] base_value = '0;
  logic [EXP_W-1:0] exponent = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [RES_W-1:0] power_result;

  mod_word_t pending_words[$];
  logic [RES_W-1:0] expected_powers[$];

  int unsigned words_total = 0;
  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned error_count = 0;
  int unsigned unreduced_count = 0;
  int unsigned zero_exp_count = 0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned hold_cycles = 0;
  logic hold_done = 1'b0;
  int unsigned cycle_count = 0;

  modular_exponentiation_unit #(
    .EXP_BITS(EXP_BITS)
  ) uut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .base_value_i(base_value),
    .exponent_i(exponent),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .power_result_o(power_result)
  );

  always #1 clk = ~clk;

  // base^expo mod the prime, scanning exponent bits from the top down
  function automatic logic [RES_W-1:0] mod_power(logic [RES_W-1:0] base,
                                                 logic [EXP_W-1:0] expo);
    logic [63:0] b;
    logic [63:0] acc;
    b = 64'(base);
    if (b >= 64'(MODULUS)) b = b - 64'(MODULUS);
    acc = 64'd1;
    for (int i = EXP_BITS - 1; i >= 0; i--) begin
      acc = (acc * acc) % 64'(MODULUS);
      if (i < EXP_W && expo[i]) acc = (acc * b) % 64'(MODULUS);
    end
    return acc[RES_W-1:0];
  endfunction

  task automatic add_word(logic [RES_W-1:0] base, logic [EXP_W-1:0] expo);
    mod_word_t w;
    w.base = base;
    w.expo = expo;
    pending_words.push_back(w);
    if (base >= MODULUS) unreduced_count++;
    if (expo == '0) zero_exp_count++;
  endtask

  // Idling is off in a middle window and over the last part of the run
  function automatic logic idle_allowed(int unsigned n);
    return !(n >= 600 && n < 800) && (n + 150 < words_total);
  endfunction

  // Drive input words; hold the word until it is taken
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_powers.push_back(mod_power(base_value, exponent));
      end
      if (in_valid && !in_ready) begin
        // keep offering the same word
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() == 0) begin
        in_valid <= 1'b0;
      end else if (idle_allowed(words_sent) && $urandom_range(0, 5) == 0) begin
        send_gap <= $urandom_range(0, 7);
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        base_value <= pending_words[0].base;
        exponent <= pending_words[0].expo;
        pending_words.pop_front();
        words_sent <= words_sent + 1;
      end
    end
  end

  // Long receiver hold-off, once, so the block fills up and stalls its input
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_cycles <= 0;
      hold_done <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (!hold_done && results_checked >= HOLD_OFF_AFTER) begin
      hold_cycles <= HOLD_OFF_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Check each result word against the oldest prediction; drive ready
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_powers.size() == 0) begin
          if (error_count < 10)
            $display("result %0d arrived with none expected: %0d",
                     results_checked, power_result);
          error_count++;
        end else begin
          if (power_result !== expected_powers[0]) begin
            if (error_count < 10)
              $display("mismatch on result %0d: expected %0d, got %0d",
                       results_checked, expected_powers[0], power_result);
            error_count++;
          end
          expected_powers.pop_front();
        end
        results_checked <= results_checked + 1;
      end
      if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        out_ready <= 1'b0;
      end else if (hold_cycles > 1) begin
        out_ready <= 1'b0;
      end else if (idle_allowed(results_checked) && $urandom_range(0, 5) == 0) begin
        recv_stall <= $urandom_range(0, 7);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Build the stimulus, release reset, wait for the drain, report
  initial begin
    logic [RES_W-1:0] b;
    logic [EXP_W-1:0] e;

    // directed: field extremes, zero exponent, unreduced bases, Fermat cases
    add_word('0, '0);
    add_word('0, 32'd1);
    add_word('0, EXP_MAX);
    add_word(30'd1, EXP_MAX);
    add_word(MODULUS - 1, '0);
    add_word(MODULUS - 1, 32'd1);
    add_word(MODULUS - 1, 32'd2);
    add_word(MODULUS - 1, EXP_MAX);
    add_word(MODULUS, 32'd5);
    add_word(MODULUS, '0);
    add_word(MODULUS + 1, EXP_MAX);
    add_word(RES_MAX, '0);
    add_word(RES_MAX, 32'd1);
    add_word(RES_MAX, EXP_MAX);
    add_word(30'd2, 32'd31);
    add_word(30'd2, 32'h8000_0000);
    add_word(30'd2, 32'(MODULUS) - 32'd1);
    add_word(30'd12345, 32'(MODULUS) - 32'd2);
    add_word(30'd3, 32'h5555_5555);
    add_word(30'd5, 32'hAAAA_AAAA);
    add_word(30'h2AAA_AAAA, 32'd1);
    add_word(30'h1555_5555, 32'd7);

    // random: mostly full-range words, plus edge bases and sparse/dense exponents
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      b = RES_W'($urandom_range(0, 32'(MODULUS) - 1));
      e = $urandom;
      case ($urandom_range(0, 9))
        0: b = RES_W'($urandom_range(32'(MODULUS), 32'(RES_MAX)));
        1: begin
          case ($urandom_range(0, 3))
            0: b = '0;
            1: b = 30'd1;
            2: b = MODULUS - 1;
            default: b = RES_MAX;
          endcase
        end
        2: e = 32'd1 << $urandom_range(0, EXP_W - 1);
        3: e = ~(32'd1 << $urandom_range(0, EXP_W - 1));
        4: e = $urandom_range(0, 15);
        5: e = $urandom & $urandom & $urandom;
        default: b = RES_W'($urandom);
      endcase
      add_word(b, e);
    end
    words_total = pending_words.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (expected_powers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d words checked (%0d unreduced bases, %0d zero exponents)",
             results_checked, unreduced_count, zero_exp_count);
    $display("tb: random idling on both channels, one %0d-cycle output hold-off, %0d errors",
             HOLD_OFF_CYCLES, error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
